// ----- rtl/rct_pkg.sv -----
// ---------------------------------------------------------------------------
// Register content tracker package
// Shared types, codes and defaults for the register content tracker.
// ---------------------------------------------------------------------------
package rct_pkg;

  localparam int TRACKED_ENTRIES_DEF = 8;
  localparam int LOAD_ENTRIES_DEF    = 4;
  localparam int KEY_DATA_BITS_DEF   = 32;

  localparam int CMD_W      = 2;
  localparam int KEY_KIND_W = 2;
  localparam int TARGET_W   = 3;
  localparam int RESULT_W   = 3;
  localparam int KIND_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP     = 2'd0,
    CMD_UPDATE     = 2'd1,
    CMD_CLEAR_LOAD = 2'd2,
    CMD_CLEAR_ACC  = 2'd3
  } cmd_t;

  localparam logic [KIND_W-1:0] KIND_SYMBOL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd5;

  typedef struct packed {
    logic [RESULT_W-1:0] reg_idx;
    logic                hit;
    logic                filled;
  } result_t;

endpackage

// ----- rtl/rct_tracker.sv -----
// ---------------------------------------------------------------------------
// Register content tracker state
// Holds the entry tags and load register ranks, matches a key against all
// entries and applies one command per fire.
// ---------------------------------------------------------------------------
module rct_tracker #(
  parameter int TRACKED_ENTRIES = rct_pkg::TRACKED_ENTRIES_DEF,
  parameter int LOAD_ENTRIES    = rct_pkg::LOAD_ENTRIES_DEF,
  parameter int KEY_DATA_BITS   = rct_pkg::KEY_DATA_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  rct_pkg::cmd_t                     cmd,
  input  logic [rct_pkg::KEY_KIND_W-1:0]    key_kind,
  input  logic [KEY_DATA_BITS-1:0]          key_data,
  input  logic [rct_pkg::TARGET_W-1:0]      target_reg,
  output rct_pkg::result_t                  result
);

  localparam int IDX_W       = $clog2(TRACKED_ENTRIES);
  localparam int RANK_W      = $clog2(LOAD_ENTRIES);
  localparam int ACCUM_ENTRY = LOAD_ENTRIES + 2;
  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(LOAD_ENTRIES - 1);

  logic [rct_pkg::KIND_W-1:0] tag_kind      [TRACKED_ENTRIES];
  logic [KEY_DATA_BITS-1:0]   tag_data      [TRACKED_ENTRIES];
  logic [rct_pkg::KIND_W-1:0] tag_kind_next [TRACKED_ENTRIES];
  logic [KEY_DATA_BITS-1:0]   tag_data_next [TRACKED_ENTRIES];
  logic [RANK_W-1:0]          ranks         [LOAD_ENTRIES];
  logic [RANK_W-1:0]          ranks_next    [LOAD_ENTRIES];

  logic [rct_pkg::KIND_W-1:0] key_kind_ext;
  logic [TRACKED_ENTRIES-1:0] match;
  logic                       found;
  logic [IDX_W-1:0]           found_idx;
  logic [IDX_W-1:0]           victim_idx;
  logic [IDX_W-1:0]           use_idx;
  logic                       promote_en;
  logic [RANK_W-1:0]          old_rank;

  assign key_kind_ext = {1'b0, key_kind};

  always_comb begin
    found      = 1'b0;
    found_idx  = '0;
    victim_idx = '0;
    for (int i = 0; i < TRACKED_ENTRIES; i++) begin
      match[i] = (tag_kind[i] == key_kind_ext) && (tag_data[i] == key_data);
    end
    for (int i = TRACKED_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
    for (int i = LOAD_ENTRIES - 1; i >= 0; i--) begin
      if (ranks[i] == '0) begin
        victim_idx = IDX_W'(i);
      end
    end
  end

  assign use_idx    = found ? found_idx : victim_idx;
  assign promote_en = (int'(use_idx) < LOAD_ENTRIES);

  always_comb begin
    old_rank = '0;
    for (int i = 0; i < LOAD_ENTRIES; i++) begin
      if (use_idx == IDX_W'(i)) begin
        old_rank = ranks[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LOAD_ENTRIES; i++) begin
      ranks_next[i] = ranks[i];
      if (cmd == rct_pkg::CMD_LOOKUP && promote_en) begin
        if (use_idx == IDX_W'(i)) begin
          ranks_next[i] = RANK_TOP;
        end else if (ranks[i] > old_rank) begin
          ranks_next[i] = ranks[i] - 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TRACKED_ENTRIES; i++) begin
      tag_kind_next[i] = tag_kind[i];
      tag_data_next[i] = tag_data[i];
      unique case (cmd)
        rct_pkg::CMD_LOOKUP: begin
          if (!found && victim_idx == IDX_W'(i)) begin
            tag_kind_next[i] = key_kind_ext;
            tag_data_next[i] = key_data;
          end
        end
        rct_pkg::CMD_UPDATE: begin
          if (key_kind_ext == rct_pkg::KIND_SYMBOL && match[i]) begin
            tag_kind_next[i] = rct_pkg::KIND_EMPTY;
          end
          if (int'(target_reg) == i) begin
            tag_kind_next[i] = key_kind_ext;
            tag_data_next[i] = key_data;
          end
        end
        rct_pkg::CMD_CLEAR_LOAD: begin
          if (i < LOAD_ENTRIES) begin
            tag_kind_next[i] = rct_pkg::KIND_EMPTY;
            tag_data_next[i] = '0;
          end
        end
        rct_pkg::CMD_CLEAR_ACC: begin
          if (i == ACCUM_ENTRY) begin
            tag_kind_next[i] = rct_pkg::KIND_EMPTY;
            tag_data_next[i] = '0;
          end
        end
        default: begin
          tag_kind_next[i] = tag_kind[i];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACKED_ENTRIES; i++) begin
        tag_kind[i] <= (i < LOAD_ENTRIES || i == ACCUM_ENTRY) ?
                       rct_pkg::KIND_EMPTY : rct_pkg::KIND_RESERVED;
        tag_data[i] <= '0;
      end
      for (int i = 0; i < LOAD_ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else if (fire) begin
      tag_kind <= tag_kind_next;
      tag_data <= tag_data_next;
      ranks    <= ranks_next;
    end
  end

  always_comb begin
    result = '0;
    if (cmd == rct_pkg::CMD_LOOKUP) begin
      result.reg_idx = rct_pkg::RESULT_W'(use_idx);
      result.hit     = found;
      result.filled  = !found;
    end
  end

endmodule

// ----- rtl/register_content_tracker_lru_top.sv -----
// ---------------------------------------------------------------------------
// Register content tracker with LRU load register replacement
// Tracks which tag each register holds and picks load registers to refill.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready) carries one command beat: cmd,
//   key_kind, key_data and target_reg. The output channel (out_valid /
//   out_ready) returns one beat per command: result_reg, hit and filled.
//   A beat is captured in an input register, matched against all tracked
//   entries from there, and its result lands in the output register. The
//   tag compare and rank update are combinational, so one beat is accepted
//   every cycle while the receiver keeps taking results.
//   When the receiver stalls, the result holds in the output register and
//   one more beat waits in the input register; in_ready then drops until the
//   output beat is taken. Reset empties the load registers and accumulator,
//   marks the other entries reserved, clears all ranks and drops both
//   pipeline registers.
// ---------------------------------------------------------------------------
module register_content_tracker_lru_top #(
  parameter int TRACKED_ENTRIES = rct_pkg::TRACKED_ENTRIES_DEF,
  parameter int LOAD_ENTRIES    = rct_pkg::LOAD_ENTRIES_DEF,
  parameter int KEY_DATA_BITS   = rct_pkg::KEY_DATA_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rct_pkg::CMD_W-1:0]       cmd,
  input  logic [rct_pkg::KEY_KIND_W-1:0]  key_kind,
  input  logic [KEY_DATA_BITS-1:0]        key_data,
  input  logic [rct_pkg::TARGET_W-1:0]    target_reg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rct_pkg::RESULT_W-1:0]    result_reg,
  output logic                            hit,
  output logic                            filled
);

  logic                           s1_valid;
  rct_pkg::cmd_t                  s1_cmd;
  logic [rct_pkg::KEY_KIND_W-1:0] s1_key_kind;
  logic [KEY_DATA_BITS-1:0]       s1_key_data;
  logic [rct_pkg::TARGET_W-1:0]   s1_target;
  logic                           advance;
  rct_pkg::result_t               result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_cmd      <= rct_pkg::cmd_t'(cmd);
      s1_key_kind <= key_kind;
      s1_key_data <= key_data;
      s1_target   <= target_reg;
    end
  end

  rct_tracker #(
    .TRACKED_ENTRIES (TRACKED_ENTRIES),
    .LOAD_ENTRIES    (LOAD_ENTRIES),
    .KEY_DATA_BITS   (KEY_DATA_BITS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .cmd        (s1_cmd),
    .key_kind   (s1_key_kind),
    .key_data   (s1_key_data),
    .target_reg (s1_target),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      result_reg <= result.reg_idx;
      hit        <= result.hit;
      filled     <= result.filled;
    end
  end

endmodule

// ----- rtl/rct_checker.sv -----
// ---------------------------------------------------------------------------
// Register content tracker checker
// Port-level checks on the tracker's result channel.
// ---------------------------------------------------------------------------
module rct_checker #(
  parameter int LOAD_ENTRIES = rct_pkg::LOAD_ENTRIES_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rct_pkg::RESULT_W-1:0] result_reg,
  input logic                         hit,
  input logic                         filled
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_reg) &&
    $stable(hit) && $stable(filled))
    else $error("stalled result beat changed");

  a_hit_xor_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && filled))
    else $error("result flags both hit and fill");

  a_fill_in_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && filled |-> (int'(result_reg) < LOAD_ENTRIES))
    else $error("fill landed outside the load registers");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit && !filled |-> result_reg == '0)
    else $error("non-lookup beat reports a register");

endmodule

bind register_content_tracker_lru_top rct_checker #(
  .LOAD_ENTRIES (LOAD_ENTRIES)
) u_rct_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .result_reg (result_reg),
  .hit        (hit),
  .filled     (filled)
);
